/* hdl/gbct_pkg.sv */
// Package for the gyro bias calibration and tracking core.
// Holds the sizing constants shared by the core and its divider, and the reset values and word codes of the core.
// Depends on nothing.
`default_nettype none

package gbct_pkg;

    localparam int MAX_ROUND_SAMPLES = 1024;
    localparam int CNT_W     = $clog2(MAX_ROUND_SAMPLES + 1);
    localparam int SUM_W     = 16 + $clog2(MAX_ROUND_SAMPLES) + 1;
    localparam int DIV_STEPS = SUM_W - 1;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [14:0] RST_STILL_LIMIT  = 15'd60;
    localparam logic [15:0] RST_STILL_NEEDED = 16'd100;
    localparam logic [15:0] RST_PP_LIMIT     = 16'd300;
    localparam logic [10:0] RST_SAMPLES      = 11'd200;
    localparam logic [2:0]  RST_ROUNDS       = 3'd5;
    localparam logic [15:0] SPREAD_INIT      = 16'h7FFF;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic signed [15:0] AXIS_MIN_INIT = 16'sh7FFF;
    localparam logic signed [15:0] AXIS_MAX_INIT = -16'sh8000;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_SLOT  = 1'b1;

    typedef enum logic [2:0] {
        REG_STILL_LIMIT  = 3'd0,
        REG_STILL_NEEDED = 3'd1,
        REG_PP_LIMIT     = 3'd2,
        REG_SAMPLES      = 3'd3,
        REG_MAX_ROUNDS   = 3'd4
    } reg_idx_t;

endpackage

`default_nettype wire

/* hdl/gbct_div.sv */
// Bit-serial signed divider: a round sum over the good sample count, truncated toward zero.
// One quotient bit per cycle; the quotient is known to fit in 16 bits.
// Depends on gbct_pkg.
`default_nettype none

module gbct_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [gbct_pkg::SUM_W-1:0] dividend,
    input  wire logic [gbct_pkg::CNT_W-1:0]      divisor,
    output logic                                 done,
    output logic signed [15:0]                   quotient
);
    import gbct_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [SUM_W-2:0]      mag_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      div_reg;
    logic [SUM_W-1:0]      abs_in;
    logic [CNT_W:0]        rem_shift;
    logic [CNT_W+1:0]      trial;
    logic                  fits;
    logic [15:0]           q_mag;

    always_comb begin
        abs_in    = dividend[SUM_W-1] ? -dividend : dividend;
        rem_shift = {rem_reg, mag_reg[SUM_W-2]};
        trial     = {1'b0, rem_shift} - {2'b00, div_reg};
        fits      = !trial[CNT_W+1];
        q_mag     = 16'(mag_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[SUM_W-1];
                mag_reg  <= abs_in[SUM_W-2:0];
                rem_reg  <= '0;
                div_reg  <= divisor;
                step_reg <= STEP_W'(DIV_STEPS);
            end else if (busy_reg) begin
                rem_reg  <= fits ? trial[CNT_W-1:0] : rem_shift[CNT_W-1:0];
                mag_reg  <= {mag_reg[SUM_W-3:0], fits};
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -q_mag : q_mag;

endmodule

`default_nettype wire

/* hdl/gyro_bias_calibrate_and_track_core.sv */
// Top level of the gyro bias calibration and tracking core with its register port.
// Uses gbct_pkg for sizing and reset values and gbct_div for the round-end means.
//
// Words of raw six-axis samples arrive on the s_ channel; result words leave on the
// m_ channel. A start word restarts calibration and gives no result. A sample word
// while calibrating or uncalibrated gives an all-zero word with ready_flag low. Once
// calibrated, a good sample gives accel unchanged and gyro less its bias; a failed
// read gives nothing. One word is worked on at a time through a single shared adder,
// one axis per cycle outside the divider, and s_ready is high only while the
// sequencer is idle. A sample word passes through the axis states and then the
// output state, where it enters the output register, or goes straight to the output
// state while neither calibrated nor calibrating. The last slot of a round adds the
// spread step, a bit-serial division per axis and the round decision, or only the
// round decision when the round had no good read. The output register lets a new
// word be accepted while a result still waits; a stalled receiver holds the sequencer
// only when the next result is ready. After reset the core is uncalibrated, biases
// are zero and the registers hold their default values. Registers must be written
// by the user over the APB port only while idle; the block does not enforce it.
`default_nettype none

module gyro_bias_calibrate_and_track_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic        s_read_ok,
    input  wire logic signed [15:0] s_accel_x_raw,
    input  wire logic signed [15:0] s_accel_y_raw,
    input  wire logic signed [15:0] s_accel_z_raw,
    input  wire logic signed [15:0] s_gyro_x_raw,
    input  wire logic signed [15:0] s_gyro_y_raw,
    input  wire logic signed [15:0] s_gyro_z_raw,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_accel_x_out,
    output logic signed [15:0] m_accel_y_out,
    output logic signed [15:0] m_accel_z_out,
    output logic signed [15:0] m_gyro_x_out,
    output logic signed [15:0] m_gyro_y_out,
    output logic signed [15:0] m_gyro_z_out,
    output logic             m_ready_flag
);
    import gbct_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_AXIS   = 8'b0000_0010,
        S_SPREAD = 8'b0000_0100,
        S_DSTART = 8'b0000_1000,
        S_DWAIT  = 8'b0001_0000,
        S_PICK   = 8'b0010_0000,
        S_RUN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [14:0] still_limit_reg;
    logic [15:0] still_needed_reg;
    logic [15:0] pp_limit_reg;
    logic [10:0] samples_reg;
    logic [2:0]  max_rounds_reg;

    logic              read_ok_reg;
    logic signed [15:0] accel_reg [3];
    logic signed [15:0] gyro_reg  [3];

    logic signed [15:0] bias_reg [3];
    logic [15:0]        still_count_reg;
    logic               ready_reg;
    logic               calibrating_reg;
    logic [2:0]         round_reg;
    logic [CNT_W-1:0]   slot_count_reg;
    logic [CNT_W-1:0]   good_count_reg;
    logic signed [SUM_W-1:0] axis_sum_reg [3];
    logic signed [15:0] axis_min_reg [3];
    logic signed [15:0] axis_max_reg [3];
    logic [15:0]        best_spread_reg;
    logic signed [15:0] best_bias_reg [3];
    logic [15:0]        spread_reg;
    logic signed [15:0] mean_reg [3];
    logic signed [15:0] corr_reg [3];
    logic               res_live_reg;
    logic [1:0]         ax_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_accel_reg [3];
    logic signed [15:0] m_gyro_reg  [3];
    logic               m_flag_reg;

    logic                    alu_sub;
    logic signed [SUM_W-1:0] alu_a;
    logic signed [SUM_W-1:0] alu_b;
    logic signed [SUM_W-1:0] alu_y;
    logic [15:0]             pp;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] slot_next;
    logic [CNT_W-1:0] good_next;
    logic             accept;
    logic             cfg_wr;
    logic             out_load;
    logic             div_start;
    logic             div_done;
    logic signed [15:0] div_q;

    logic               have_good;
    logic               better;
    logic [3:0]         round_next;
    logic [2:0]         round_limit;
    logic signed [15:0] best_bias_new [3];

    logic signed [15:0] cz;
    logic [15:0]        cz_abs;
    logic               still;
    logic [15:0]        still_inc;

    assign accept   = s_valid && s_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign pready   = 1'b1;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_STILL_LIMIT:  prdata = 32'(still_limit_reg);
            REG_STILL_NEEDED: prdata = 32'(still_needed_reg);
            REG_PP_LIMIT:     prdata = 32'(pp_limit_reg);
            REG_SAMPLES:      prdata = 32'(samples_reg);
            REG_MAX_ROUNDS:   prdata = 32'(max_rounds_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (samples_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(samples_reg) > MAX_ROUND_SAMPLES) begin
            n_eff = CNT_W'(MAX_ROUND_SAMPLES);
        end else begin
            n_eff = CNT_W'(samples_reg);
        end
        slot_next   = slot_count_reg + 1'b1;
        good_next   = good_count_reg + CNT_W'(read_ok_reg);
        round_limit = (max_rounds_reg == '0) ? 3'd1 : max_rounds_reg;
        round_next  = {1'b0, round_reg} + 4'd1;
    end

    always_comb begin
        alu_sub = 1'b0;
        alu_a   = axis_sum_reg[ax_reg];
        alu_b   = SUM_W'(gyro_reg[ax_reg]);
        case (state_reg)
            S_SPREAD: begin
                alu_sub = 1'b1;
                alu_a   = SUM_W'(axis_max_reg[ax_reg]);
                alu_b   = SUM_W'(axis_min_reg[ax_reg]);
            end
            S_RUN: begin
                alu_sub = 1'b1;
                alu_a   = SUM_W'(gyro_reg[ax_reg]);
                alu_b   = SUM_W'(bias_reg[ax_reg]);
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
        pp    = alu_y[15:0];
    end

    always_comb begin
        have_good = (good_count_reg != '0);
        better    = have_good && (spread_reg < best_spread_reg);
        for (int k = 0; k < 3; k++) begin
            best_bias_new[k] = better ? mean_reg[k] : best_bias_reg[k];
        end
        cz        = alu_y[15:0];
        cz_abs    = cz[15] ? -cz : cz;
        still     = (cz != -16'sh8000) && (cz_abs <= {1'b0, still_limit_reg});
        still_inc = (still_count_reg != COUNT_MAX) ? still_count_reg + 1'b1 : still_count_reg;
    end

    assign div_start = (state_reg == S_DSTART);

    gbct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (axis_sum_reg[ax_reg]),
        .divisor  (good_count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_limit_reg  <= RST_STILL_LIMIT;
            still_needed_reg <= RST_STILL_NEEDED;
            pp_limit_reg     <= RST_PP_LIMIT;
            samples_reg      <= RST_SAMPLES;
            max_rounds_reg   <= RST_ROUNDS;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[4:2]))
                REG_STILL_LIMIT:  still_limit_reg  <= pwdata[14:0];
                REG_STILL_NEEDED: still_needed_reg <= pwdata[15:0];
                REG_PP_LIMIT:     pp_limit_reg     <= pwdata[15:0];
                REG_SAMPLES:      samples_reg      <= pwdata[10:0];
                REG_MAX_ROUNDS:   max_rounds_reg   <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            ready_reg       <= 1'b0;
            calibrating_reg <= 1'b0;
            still_count_reg <= '0;
            round_reg       <= '0;
            slot_count_reg  <= '0;
            good_count_reg  <= '0;
            best_spread_reg <= SPREAD_INIT;
            ax_reg          <= '0;
            m_valid_reg     <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                bias_reg[k]      <= '0;
                best_bias_reg[k] <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        read_ok_reg  <= s_read_ok;
                        accel_reg[0] <= s_accel_x_raw;
                        accel_reg[1] <= s_accel_y_raw;
                        accel_reg[2] <= s_accel_z_raw;
                        gyro_reg[0]  <= s_gyro_x_raw;
                        gyro_reg[1]  <= s_gyro_y_raw;
                        gyro_reg[2]  <= s_gyro_z_raw;
                        ax_reg       <= '0;
                        res_live_reg <= 1'b0;
                        if (s_action == ACT_START) begin
                            ready_reg       <= 1'b0;
                            calibrating_reg <= 1'b1;
                            round_reg       <= '0;
                            slot_count_reg  <= '0;
                            good_count_reg  <= '0;
                            best_spread_reg <= SPREAD_INIT;
                            for (int k = 0; k < 3; k++) begin
                                axis_sum_reg[k]  <= '0;
                                axis_min_reg[k]  <= AXIS_MIN_INIT;
                                axis_max_reg[k]  <= AXIS_MAX_INIT;
                                best_bias_reg[k] <= '0;
                            end
                        end else if (ready_reg) begin
                            if (s_read_ok) begin
                                state_reg <= S_RUN;
                            end
                        end else if (calibrating_reg) begin
                            state_reg <= S_AXIS;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end
                end

                S_AXIS: begin
                    if (read_ok_reg) begin
                        axis_sum_reg[ax_reg] <= alu_y;
                        if (gyro_reg[ax_reg] < axis_min_reg[ax_reg]) begin
                            axis_min_reg[ax_reg] <= gyro_reg[ax_reg];
                        end
                        if (gyro_reg[ax_reg] > axis_max_reg[ax_reg]) begin
                            axis_max_reg[ax_reg] <= gyro_reg[ax_reg];
                        end
                    end
                    if (ax_reg == 2'd2) begin
                        ax_reg         <= '0;
                        good_count_reg <= good_next;
                        slot_count_reg <= slot_next;
                        spread_reg     <= '0;
                        if (slot_next >= n_eff) begin
                            state_reg <= (good_next != '0) ? S_SPREAD : S_PICK;
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end

                S_SPREAD: begin
                    if (pp > spread_reg) begin
                        spread_reg <= pp;
                    end
                    if (ax_reg == 2'd2) begin
                        ax_reg    <= '0;
                        state_reg <= S_DSTART;
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end

                S_DSTART: begin
                    state_reg <= S_DWAIT;
                end

                S_DWAIT: begin
                    if (div_done) begin
                        mean_reg[ax_reg] <= div_q;
                        if (ax_reg == 2'd2) begin
                            ax_reg    <= '0;
                            state_reg <= S_PICK;
                        end else begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= S_DSTART;
                        end
                    end
                end

                S_PICK: begin
                    if (better) begin
                        best_spread_reg <= spread_reg;
                        for (int k = 0; k < 3; k++) begin
                            best_bias_reg[k] <= mean_reg[k];
                        end
                    end
                    if (have_good && (spread_reg <= pp_limit_reg)) begin
                        calibrating_reg <= 1'b0;
                        ready_reg       <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            bias_reg[k] <= mean_reg[k];
                        end
                    end else begin
                        round_reg <= round_next[2:0];
                        if (round_next >= {1'b0, round_limit}) begin
                            calibrating_reg <= 1'b0;
                            ready_reg       <= 1'b1;
                            for (int k = 0; k < 3; k++) begin
                                bias_reg[k] <= best_bias_new[k];
                            end
                        end else begin
                            slot_count_reg <= '0;
                            good_count_reg <= '0;
                            for (int k = 0; k < 3; k++) begin
                                axis_sum_reg[k] <= '0;
                                axis_min_reg[k] <= AXIS_MIN_INIT;
                                axis_max_reg[k] <= AXIS_MAX_INIT;
                            end
                        end
                    end
                    state_reg <= S_OUT;
                end

                S_RUN: begin
                    corr_reg[ax_reg] <= alu_y[15:0];
                    if (ax_reg == 2'd2) begin
                        ax_reg       <= '0;
                        res_live_reg <= 1'b1;
                        state_reg    <= S_OUT;
                        if (still) begin
                            still_count_reg <= still_inc;
                            if (still_inc >= still_needed_reg) begin
                                if (!cz[15] && (cz != '0)) begin
                                    bias_reg[2] <= bias_reg[2] + 16'sd1;
                                end else if (cz[15]) begin
                                    bias_reg[2] <= bias_reg[2] - 16'sd1;
                                end
                            end
                        end else begin
                            still_count_reg <= '0;
                        end
                    end else begin
                        ax_reg <= ax_reg + 1'b1;
                    end
                end

                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_flag_reg <= res_live_reg;
            for (int k = 0; k < 3; k++) begin
                m_accel_reg[k] <= res_live_reg ? accel_reg[k] : '0;
                m_gyro_reg[k]  <= res_live_reg ? corr_reg[k] : '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_accel_x_out = m_accel_reg[0];
    assign m_accel_y_out = m_accel_reg[1];
    assign m_accel_z_out = m_accel_reg[2];
    assign m_gyro_x_out  = m_gyro_reg[0];
    assign m_gyro_y_out  = m_gyro_reg[1];
    assign m_gyro_z_out  = m_gyro_reg[2];
    assign m_ready_flag  = m_flag_reg;

    // Calibration and run mode exclude each other.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ready_reg && calibrating_reg))
        else $error("ready and calibrating both set");

    // A round never holds more good reads than slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        good_count_reg <= slot_count_reg)
        else $error("good count exceeds slot count");

    // Calibration ends, and its biases are adopted, only in the round decision.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ready_reg) |-> $past(state_reg == S_PICK))
        else $error("ready raised outside the round decision");

    // Once a good read has been taken the tracked extremes of the x axis are ordered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (good_count_reg != '0) |-> (axis_min_reg[0] <= axis_max_reg[0]))
        else $error("axis minimum above maximum");

endmodule

`default_nettype wire
